/* hw/rtl/zndp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the z-normalized distance profile unit.
// Used by every module of the block; depends on nothing.
package zndp_pkg;

	// Default depth of the history chain and the query store.
	localparam int DefMaxQueryLen = 128;

	// Input operation codes carried in the slave-side tuser.
	localparam logic [1:0] OP_QUERY_WRITE = 2'd0;
	localparam logic [1:0] OP_SAMPLE      = 2'd1;
	localparam logic [1:0] OP_NEW_SERIES  = 2'd2;

	// Register byte-address bit that selects the register index.
	localparam logic REG_QUERY_LENGTH = 1'b0;

	// Saturation limits of signed Q8.16.
	localparam logic [23:0] Q_MAX = 24'h7FFFFF;
	localparam logic [23:0] Q_MIN = 24'h800000;

	// One history entry held by a cell.
	typedef struct packed {
		logic [31:0] sample;
		logic [31:0] mean;
		logic [31:0] dev;
	} zndp_hist_t;

	// Control shared by all cells of the chain.
	typedef struct packed {
		logic shift;
		logic clear;
	} zndp_cell_ctl_t;

endpackage

/* hw/rtl/zndp_cell.sv */
`timescale 1ns / 1ps
// One cell of the history chain: holds one sample with its window mean and deviation.
// Depends on zndp_pkg.
module zndp_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  zndp_pkg::zndp_cell_ctl_t ctl,
	input  zndp_pkg::zndp_hist_t    din,
	output zndp_pkg::zndp_hist_t    dout
);
	import zndp_pkg::*;

	zndp_hist_t entry_q;

	// Take the neighbor's entry on a shift, drop to zero on a new series.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctl.clear) begin
			entry_q <= '0;
		end else if (ctl.shift) begin
			entry_q <= din;
		end
	end

	assign dout = entry_q;

endmodule

/* hw/rtl/zndp_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: 49-bit dividend by 32-bit divisor.
// Depends on zndp_pkg.
module zndp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [48:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [48:0] quotient
);
	import zndp_pkg::*;

	logic [32:0] rem_q;
	logic [48:0] quo_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic        fits;

	// Bring down the next dividend bit and try the subtraction.
	assign trial = {rem_q[31:0], quo_q[48]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd48) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and the dividend register that fills with quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[47:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hw/rtl/zndp_isqrt.sv */
`timescale 1ns / 1ps
// Integer square root of a 64-bit value, one result bit per cycle.
// Depends on zndp_pkg.
module zndp_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	import zndp_pkg::*;

	logic [63:0] n_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] cand;

	assign cand = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Digit-by-digit root: the test bit walks down two places a cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= radicand;
			r_q   <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (n_q >= cand) begin
				n_q <= n_q - cand;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = (r_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : r_q[31:0];

endmodule

/* hw/rtl/znorm_distance_profile_unit.sv */
`timescale 1ns / 1ps
// Top level of the z-normalized distance profile unit: history cell chain, query store,
// shared divider and square root. Depends on zndp_pkg, zndp_cell, zndp_div, zndp_isqrt.
//
// Query writes, new-series commands and samples that do not yet complete a window are
// taken without starting a pass. A sample that completes a window of L elements starts a
// pass: the history chain of MAX_QUERY_LEN cells rotates once past its tail, every window
// element goes around the shared 49-step divider, and the sum of squares goes through the
// 32-step square root. A window with zero deviation skips the divider and root. One item
// is worked at a time; a new item is taken once the previous pass has finished. A finished
// result waits in an output register, and a pass that ends while that register is still
// occupied holds until the waiting result has been transferred.
module znorm_distance_profile_unit #(
	parameter int MAX_QUERY_LEN = zndp_pkg::DefMaxQueryLen
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata from bit 0: query_index[6:0], query_value[30:7], sample[62:31],
	// window_mean[94:63], window_deviation[126:95], zero fill [127].
	input  logic [127:0] s_tdata,
	// s_tuser: opcode[1:0].
	input  logic [1:0]   s_tuser,
	// Result stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata from bit 0: distance[31:0], window_start[63:32].
	output logic [63:0]  m_tdata,
	// m_tuser: zero_deviation[0].
	output logic [0:0]   m_tuser,
	// Configuration port.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import zndp_pkg::*;

	localparam int AW = (MAX_QUERY_LEN > 1) ? $clog2(MAX_QUERY_LEN) : 1;
	localparam int CW = $clog2(MAX_QUERY_LEN + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ROT  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_ACC  = 3'd3;
	localparam logic [2:0] S_SQRT = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	// Configuration register.
	logic [7:0] qlen_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q <= 8'd128;
		end else if (cfg_wr && paddr[2] == REG_QUERY_LENGTH) begin
			qlen_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_QUERY_LENGTH) ? {24'd0, qlen_q} : 32'd0;

	// Input field decode.
	logic [1:0]  in_op;
	logic [6:0]  in_qidx;
	logic [23:0] in_qval;
	zndp_hist_t  in_hist;
	logic        in_xfer;

	assign in_op          = s_tuser;
	assign in_qidx        = s_tdata[6:0];
	assign in_qval        = s_tdata[30:7];
	assign in_hist.sample = s_tdata[62:31];
	assign in_hist.mean   = s_tdata[94:63];
	assign in_hist.dev    = s_tdata[126:95];

	// Control state.
	logic [2:0]    state_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] skip_q;
	logic [CW-1:0] rot_q;
	logic [31:0]   seen_q;
	logic [31:0]   wstart_q;
	logic          cap_q;
	logic          zdev_q;
	logic          neg_q;
	logic [31:0]   mean_q;
	logic [31:0]   dev_q;
	logic [63:0]   sum_q;
	logic [23:0]   tabs_q;
	logic          oval_q;
	logic [31:0]   odist_q;
	logic [31:0]   owstart_q;
	logic          oflag_q;
	logic          out_load;

	assign s_tready = state_q == S_IDLE;
	assign in_xfer  = s_tvalid && s_tready;
	assign out_load = (state_q == S_OUT) && (!oval_q || m_tready);

	// Effective window length for this sample.
	int          len_i;
	logic [CW-1:0] fill_next;

	always_comb begin
		if (qlen_q == 8'd0) begin
			len_i = 1;
		end else if (int'(qlen_q) > MAX_QUERY_LEN) begin
			len_i = MAX_QUERY_LEN;
		end else begin
			len_i = int'(qlen_q);
		end
		fill_next = (int'(fill_q) < MAX_QUERY_LEN) ? fill_q + CW'(1) : fill_q;
	end

	// History cell chain: new samples enter at cell 0; in a rotation the tail wraps round.
	zndp_hist_t     cell_out [MAX_QUERY_LEN];
	zndp_hist_t     cell_in  [MAX_QUERY_LEN];
	zndp_cell_ctl_t cell_ctl;
	logic           rot_step;
	logic           rot_mode;
	zndp_hist_t     tail;

	assign tail = cell_out[MAX_QUERY_LEN-1];

	assign cell_ctl.shift = (in_xfer && in_op == OP_SAMPLE) || rot_step;
	assign cell_ctl.clear = in_xfer && in_op == OP_NEW_SERIES;
	assign rot_mode       = state_q != S_IDLE;

	for (genvar k = 0; k < MAX_QUERY_LEN; k++) begin : g_cell
		if (k == 0) begin : g_head
			assign cell_in[k] = rot_mode ? tail : in_hist;
		end else begin : g_body
			assign cell_in[k] = cell_out[k-1];
		end
		zndp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cell_ctl),
			.din    (cell_in[k]),
			.dout   (cell_out[k])
		);
	end

	// Query store with registered read.
	logic [23:0]   qmem [MAX_QUERY_LEN];
	logic [23:0]   qrd_q;
	logic [AW-1:0] qraddr;
	logic [31:0]   qidx_ext;
	logic [CW-1:0] elem_j;

	assign qidx_ext = {25'd0, in_qidx};
	assign elem_j   = rot_q - skip_q;
	assign qraddr   = elem_j[AW-1:0];

	always_ff @(posedge clk) begin
		if (in_xfer && in_op == OP_QUERY_WRITE && int'(qidx_ext) < MAX_QUERY_LEN) begin
			qmem[qidx_ext[AW-1:0]] <= in_qval;
		end
		qrd_q <= qmem[qraddr];
	end

	// Element arithmetic: centered magnitude, saturated z value, term and square.
	logic [32:0] diff;
	logic [32:0] mag;
	logic        div_start;
	logic        div_done;
	logic [48:0] div_quo;
	logic [23:0] zval;
	logic [24:0] term_w;
	logic [23:0] term;
	logic [23:0] tabs;
	logic [47:0] sq;

	always_comb begin
		diff = {tail.sample[31], tail.sample} - {mean_q[31], mean_q};
		mag  = diff[32] ? (~diff + 33'd1) : diff;
		if (neg_q) begin
			zval = (div_quo >= 49'd8388608) ? Q_MIN : (~{1'b0, div_quo[22:0]} + 24'd1);
		end else begin
			zval = (div_quo > 49'd8388607) ? Q_MAX : {1'b0, div_quo[22:0]};
		end
		term_w = {zval[23], zval} - {qrd_q[23], qrd_q};
		if (term_w[24] != term_w[23]) begin
			term = term_w[24] ? Q_MIN : Q_MAX;
		end else begin
			term = term_w[23:0];
		end
		tabs = term[23] ? (~term + 24'd1) : term;
		sq   = tabs_q * tabs_q;
	end

	zndp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({mag, 16'd0}),
		.divisor  (dev_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	logic        sq_start;
	logic        sq_done;
	logic [31:0] sq_root;

	zndp_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sum_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	// Step decisions of the rotation pass.
	logic rot_done;
	logic rot_skip;
	logic rot_cap;

	assign rot_done  = int'(rot_q) == MAX_QUERY_LEN;
	assign rot_skip  = rot_q < skip_q;
	assign rot_cap   = (rot_q == skip_q) && !cap_q;
	assign div_start = (state_q == S_ROT) && !rot_done && !rot_skip && !rot_cap && !zdev_q;
	assign rot_step  = ((state_q == S_ROT) && !rot_done && !rot_cap && (rot_skip || zdev_q))
	                   || (state_q == S_ACC);
	assign sq_start  = (state_q == S_ROT) && rot_done && !zdev_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			seen_q  <= '0;
			rot_q   <= '0;
			cap_q   <= 1'b0;
			zdev_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer && in_op == OP_NEW_SERIES) begin
						fill_q <= '0;
						seen_q <= '0;
					end else if (in_xfer && in_op == OP_SAMPLE) begin
						fill_q <= fill_next;
						seen_q <= seen_q + 32'd1;
						if (int'(fill_next) >= len_i) begin
							state_q <= S_ROT;
							rot_q   <= '0;
							cap_q   <= 1'b0;
							zdev_q  <= 1'b0;
						end
					end
				end
				S_ROT: begin
					if (rot_done) begin
						state_q <= zdev_q ? S_OUT : S_SQRT;
					end else if (rot_cap) begin
						cap_q  <= 1'b1;
						zdev_q <= tail.dev == 32'd0;
					end else if (rot_skip || zdev_q) begin
						rot_q <= rot_q + CW'(1);
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					rot_q   <= rot_q + CW'(1);
					state_q <= S_ROT;
				end
				S_SQRT: begin
					if (sq_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: loaded when a pass ends, emptied by the result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (out_load) begin
			oval_q <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			oval_q <= 1'b0;
		end
	end

	// Datapath registers of the pass.
	always_ff @(posedge clk) begin
		if (in_xfer && in_op == OP_SAMPLE) begin
			len_q    <= CW'(len_i);
			skip_q   <= CW'(MAX_QUERY_LEN - len_i);
			wstart_q <= seen_q - 32'(len_i - 1);
			sum_q    <= '0;
		end
		if (state_q == S_ROT && rot_cap) begin
			mean_q <= tail.mean;
			dev_q  <= tail.dev;
		end
		if (div_start) begin
			neg_q <= diff[32];
		end
		if (state_q == S_DIV && div_done) begin
			tabs_q <= tabs;
		end
		if (state_q == S_ACC) begin
			sum_q <= sum_q + {16'd0, sq};
		end
		if (out_load) begin
			odist_q   <= zdev_q ? 32'hFFFF_FFFF : sq_root;
			oflag_q   <= zdev_q;
			owstart_q <= wstart_q;
		end
	end

	assign m_tvalid = oval_q;
	assign m_tdata  = {owstart_q, odist_q};
	assign m_tuser  = oflag_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= MAX_QUERY_LEN)
		else $error("fill count exceeds chain depth");
	a_rot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(rot_q) <= MAX_QUERY_LEN)
		else $error("rotation count exceeds chain depth");
	a_out_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("finished pass without a result");
	a_len_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (len_q <= fill_q))
		else $error("window pass started before the window was full");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("waiting result changed before its transfer");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for znorm_distance_profile_unit: directed table, then random
// series under several window lengths. Depends on zndp_pkg and the unit's RTL.
module testbench;
	import zndp_pkg::*;

	localparam int MaxLen = 128;

	// One row of the directed stimulus table.
	typedef struct packed {
		logic [1:0]  op;
		logic [6:0]  qidx;
		logic [23:0] qval;
		logic [31:0] smp;
		logic [31:0] mn;
		logic [31:0] dv;
		logic        typed;
		logic [31:0] distance;
		logic [31:0] wstart;
		logic        zflag;
	} stim_row_t;

	// One expected window distance.
	typedef struct packed {
		logic [31:0] distance;
		logic [31:0] wstart;
		logic        zflag;
	} window_res_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	// Typed expectation travelling with the item on the input side.
	logic         cur_typed;
	window_res_t  cur_res;

	// Predictor state.
	logic [7:0]        len_reg;
	logic signed [23:0] q_mem [MaxLen];
	longint            smp_hist [MaxLen];
	longint            mean_hist [MaxLen];
	longint            dev_hist [MaxLen];
	logic [31:0]       seen_cnt;
	int                ring_wr;
	int                fill_cnt;

	window_res_t dist_queue [$];
	int          errors;
	int          burst_left;
	logic        hold_rx;
	logic        start_hold;
	int          rx_mode;

	stim_row_t dir_rows [15] = '{
		'{OP_NEW_SERIES, 7'd0, 24'd0, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0},
		'{OP_SAMPLE, 7'd0, 24'd0, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0},
		'{OP_SAMPLE, 7'd0, 24'd0, 32'd1, 32'd0, 32'd1, 1'b1, 32'hFFFFFFFF, 32'd0, 1'b1},
		'{OP_SAMPLE, 7'd0, 24'd0, 32'h7FFFFFFF, 32'h80000000, 32'd1, 1'b0, 32'd0, 32'd0, 1'b0},
		'{OP_SAMPLE, 7'd0, 24'd0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0,
			32'd0, 32'd0, 1'b0},
		'{OP_SAMPLE, 7'd0, 24'd0, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 1'b0, 32'd0, 32'd0, 1'b0},
		'{2'd3, 7'h7F, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0,
			32'd0, 32'd0, 1'b0},
		'{OP_QUERY_WRITE, 7'd127, 24'h7FFFFF, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0},
		'{OP_QUERY_WRITE, 7'd0, 24'h800000, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0},
		'{OP_SAMPLE, 7'd0, 24'd0, 32'd65536, 32'd0, 32'd65536, 1'b0, 32'd0, 32'd0, 1'b0},
		'{OP_QUERY_WRITE, 7'd1, 24'h7FFFFF, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0},
		'{OP_SAMPLE, 7'd0, 24'd0, 32'd200000, 32'hFFFF0000, 32'd3000, 1'b0, 32'd0, 32'd0, 1'b0},
		'{OP_NEW_SERIES, 7'd0, 24'd0, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0},
		'{OP_SAMPLE, 7'd0, 24'd0, 32'd5, 32'd5, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0},
		'{OP_SAMPLE, 7'd0, 24'd0, 32'd9, 32'd2, 32'd700, 1'b1, 32'hFFFFFFFF, 32'd0, 1'b1}
	};

	znorm_distance_profile_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #4 clk = ~clk;

	// Integer square root, rounded down.
	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Advance the predicted state by one accepted item; returns 1 when a window completes.
	function automatic bit predict_window(input logic [1:0] op, input logic [6:0] qidx,
			input logic [23:0] qval, input logic [31:0] smp, input logic [31:0] mn,
			input logic [31:0] dv, output window_res_t res);
		int               wlen;
		int               cur;
		int               first;
		int               pos;
		logic [31:0]      idx_now;
		longint           diff;
		longint           z;
		longint           t;
		longint unsigned  mag;
		longint unsigned  qz;
		longint unsigned  acc;
		longint unsigned  root;
		res = '0;
		if (op == OP_QUERY_WRITE) begin
			q_mem[qidx] = qval;
			return 0;
		end
		if (op == OP_NEW_SERIES) begin
			for (int k = 0; k < MaxLen; k++) begin
				smp_hist[k] = 0;
				mean_hist[k] = 0;
				dev_hist[k] = 0;
			end
			seen_cnt = 0;
			ring_wr = 0;
			fill_cnt = 0;
			return 0;
		end
		if (op != OP_SAMPLE)
			return 0;
		smp_hist[ring_wr] = longint'($signed(smp));
		mean_hist[ring_wr] = longint'($signed(mn));
		dev_hist[ring_wr] = longint'({32'd0, dv});
		if (fill_cnt < MaxLen)
			fill_cnt++;
		wlen = (len_reg == 0) ? 1 : ((len_reg > MaxLen) ? MaxLen : int'(len_reg));
		cur = ring_wr;
		idx_now = seen_cnt;
		seen_cnt = seen_cnt + 32'd1;
		ring_wr = (ring_wr + 1 >= MaxLen) ? 0 : ring_wr + 1;
		if (fill_cnt < wlen)
			return 0;
		first = (cur + MaxLen - (wlen - 1)) % MaxLen;
		res.wstart = idx_now - 32'(wlen - 1);
		if (dev_hist[first] == 0) begin
			res.distance = 32'hFFFFFFFF;
			res.zflag = 1'b1;
			return 1;
		end
		acc = 0;
		pos = first;
		for (int j = 0; j < wlen; j++) begin
			diff = smp_hist[pos] - mean_hist[first];
			mag = (diff < 0) ? longint'(-diff) : longint'(diff);
			qz = (mag << 16) / longint'(dev_hist[first]);
			if (diff < 0)
				z = (qz >= 64'd8388608) ? -64'sd8388608 : -longint'(qz);
			else
				z = (qz > 64'd8388607) ? 64'sd8388607 : longint'(qz);
			t = z - longint'(q_mem[j]);
			if (t > 8388607) t = 8388607;
			if (t < -8388608) t = -8388608;
			mag = (t < 0) ? longint'(-t) : longint'(t);
			acc = acc + mag * mag;
			pos = (pos + 1 >= MaxLen) ? 0 : pos + 1;
		end
		root = int_sqrt(acc);
		res.distance = (root > 64'hFFFFFFFF) ? 32'hFFFFFFFF : root[31:0];
		res.zflag = 1'b0;
		return 1;
	endfunction

	// Record expectations for every input transfer.
	always @(posedge clk) begin
		window_res_t r;
		if (arst_n && s_tvalid && s_tready) begin
			if (predict_window(s_tuser, s_tdata[6:0], s_tdata[30:7], s_tdata[62:31],
					s_tdata[94:63], s_tdata[126:95], r))
				dist_queue.push_back(cur_typed ? cur_res : r);
		end
	end

	// Compare every result transfer with the oldest expectation.
	always @(posedge clk) begin
		window_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (dist_queue.size() == 0) begin
				$display("%0t: unexpected result dist=%h start=%h flag=%b", $realtime,
					m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
				errors++;
			end else begin
				e = dist_queue.pop_front();
				if (m_tdata[31:0] !== e.distance) begin
					$display("%0t: distance expected %h actual %h", $realtime, e.distance,
						m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== e.wstart) begin
					$display("%0t: window_start expected %h actual %h", $realtime, e.wstart,
						m_tdata[63:32]);
					errors++;
				end
				if (m_tuser[0] !== e.zflag) begin
					$display("%0t: zero_deviation expected %b actual %b", $realtime, e.zflag,
						m_tuser[0]);
					errors++;
				end
			end
		end
	end

	// Receiver stall pattern; the mode changes now and then.
	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0)
			rx_mode <= $urandom_range(0, 2);
		if (hold_rx)
			m_tready <= 1'b0;
		else if (rx_mode == 0)
			m_tready <= 1'b1;
		else if (rx_mode == 1)
			m_tready <= ($urandom_range(0, 3) != 0);
		else
			m_tready <= ($urandom_range(0, 3) == 0);
	end

	// Long receiver hold-off so the unit backs up onto its input.
	initial begin
		hold_rx = 1'b0;
		wait (start_hold);
		@(posedge clk);
		hold_rx = 1'b1;
		repeat (3000) @(posedge clk);
		hold_rx = 1'b0;
	end

	// Offer one item, with bursts and gaps, and wait for its transfer.
	task automatic send_item(input stim_row_t row);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 2) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= row.op;
		s_tdata <= {1'b0, row.dv, row.mn, row.smp, row.qval, row.qidx};
		cur_typed <= row.typed;
		cur_res <= '{row.distance, row.wstart, row.zflag};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Drain all pending results, then let any trailing item without a result finish.
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (dist_queue.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// Register write over the configuration port while the unit is idle.
	task automatic write_length(input logic [7:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'd0;
		pwdata <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		len_reg = v;
	endtask

	// Random item; mostly samples with moderate normalized values.
	task automatic send_random(input bit samples_only);
		stim_row_t row;
		int sel;
		row = '0;
		row.qidx = 7'($urandom);
		row.qval = 24'($urandom);
		row.smp = $urandom;
		row.mn = $urandom;
		row.dv = $urandom;
		sel = samples_only ? 50 : $urandom_range(0, 99);
		if (sel < 8)
			row.op = OP_QUERY_WRITE;
		else if (sel < 11)
			row.op = OP_NEW_SERIES;
		else if (sel < 14)
			row.op = 2'd3;
		else begin
			row.op = OP_SAMPLE;
			sel = $urandom_range(0, 9);
			if (sel == 0)
				row.dv = 32'd0;
			else if (sel < 8) begin
				row.mn = $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
				row.smp = row.mn + $urandom_range(0, 32'h0007FFFF) - 32'h00040000;
				row.dv = $urandom_range(32'h00001000, 32'h00100000);
			end else if (sel == 8)
				row.dv = $urandom_range(1, 4);
		end
		send_item(row);
	endtask

	// Main sequence.
	initial begin
		stim_row_t row;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_typed = 1'b0;
		cur_res = '0;
		errors = 0;
		burst_left = 0;
		start_hold = 1'b0;
		rx_mode = 0;
		len_reg = 8'd128;
		seen_cnt = 0;
		ring_wr = 0;
		fill_cnt = 0;
		for (int k = 0; k < MaxLen; k++) begin
			q_mem[k] = 0;
			smp_hist[k] = 0;
			mean_hist[k] = 0;
			dev_hist[k] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole query store before any window reads it.
		for (int k = 0; k < MaxLen; k++) begin
			row = '0;
			row.op = OP_QUERY_WRITE;
			row.qidx = 7'(k);
			row.qval = (k % 3 == 0) ? 24'($urandom) :
				24'($urandom_range(0, 24'h3FFFF) - 24'h20000);
			send_item(row);
		end
		drain();

		// Directed table with two-element windows.
		write_length(8'd2);
		foreach (dir_rows[i])
			send_item(dir_rows[i]);
		drain();

		// Single-element windows, with a long receiver hold-off.
		write_length(8'd1);
		start_hold = 1'b1;
		repeat (200) send_random(1'b0);
		drain();

		write_length(8'd2);
		repeat (300) send_random(1'b0);
		drain();

		write_length(8'd3);
		repeat (250) send_random(1'b0);
		drain();

		// Length zero behaves as one.
		write_length(8'd0);
		repeat (120) send_random(1'b0);
		drain();

		// Length changed in the middle of a series.
		write_length(8'd4);
		repeat (80) send_random(1'b1);
		drain();
		write_length(8'd6);
		repeat (80) send_random(1'b1);
		drain();

		// Full length and an out-of-range length on fresh series.
		write_length(8'd128);
		row = '0;
		row.op = OP_NEW_SERIES;
		send_item(row);
		repeat (131) send_random(1'b1);
		drain();
		write_length(8'd255);
		send_item(row);
		repeat (130) send_random(1'b1);
		drain();

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Run limit.
	initial begin
		#40000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* znorm_distance_profile_unit.f */
hw/rtl/zndp_pkg.sv
hw/rtl/zndp_cell.sv
hw/rtl/zndp_div.sv
hw/rtl/zndp_isqrt.sv
hw/rtl/znorm_distance_profile_unit.sv
sim/testbench.sv
